/* rtl/core/ica_pkg.sv */
// Package for the IMU complementary attitude estimator.
// Holds the register indexes, mode codes and the arctangent table; no dependencies.
package ica_pkg;

   localparam int unsigned TabLen  = 24;
   localparam int unsigned TabFrac = 24;

   // Configuration register indexes
   localparam logic [2:0] CSR_MODE       = 3'd0;
   localparam logic [2:0] CSR_RATE_GAIN  = 3'd1;
   localparam logic [2:0] CSR_YAW_GAIN   = 3'd2;
   localparam logic [2:0] CSR_GYRO_WT    = 3'd3;
   localparam logic [2:0] CSR_YAW_DBAND  = 3'd4;
   localparam logic [2:0] CSR_ROLL_TRIM  = 3'd5;

   // Operating modes
   localparam logic [1:0] MODE_GYRO  = 2'd0;
   localparam logic [1:0] MODE_ACCEL = 2'd1;
   localparam logic [1:0] MODE_FUSED = 2'd2;

   // atan(2^-i) in degrees, Q.24
   function automatic logic [31:0] atan_q24(input logic [4:0] i);
      logic [31:0] v;
      case (i)
         5'd0:  v = 32'd754974720;
         5'd1:  v = 32'd445687602;
         5'd2:  v = 32'd235489088;
         5'd3:  v = 32'd119537938;
         5'd4:  v = 32'd60000934;
         5'd5:  v = 32'd30029717;
         5'd6:  v = 32'd15018523;
         5'd7:  v = 32'd7509720;
         5'd8:  v = 32'd3754917;
         5'd9:  v = 32'd1877466;
         5'd10: v = 32'd938734;
         5'd11: v = 32'd469367;
         5'd12: v = 32'd234684;
         5'd13: v = 32'd117342;
         5'd14: v = 32'd58671;
         5'd15: v = 32'd29335;
         5'd16: v = 32'd14668;
         5'd17: v = 32'd7334;
         5'd18: v = 32'd3667;
         5'd19: v = 32'd1833;
         5'd20: v = 32'd917;
         5'd21: v = 32'd458;
         5'd22: v = 32'd229;
         5'd23: v = 32'd115;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

/* rtl/core/imu_complementary_attitude.sv */
// IMU complementary attitude estimator, top level.
// Sequenced over one shared CORDIC stage and one shared 33x33 multiplier; a vectoring
// pass ends early once y reaches zero. A new sample is accepted only in idle, after the
// previous result has been loaded into the response register.
// Reset (synchronous, active high) clears the angles and loads the register defaults.
module imu_complementary_attitude
   import ica_pkg::*;
#(
   parameter int unsigned CORDIC_STEPS    = 16,
   parameter int unsigned ANGLE_FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z (16 bits each)
   input  logic [95:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // pitch_out, roll_out, yaw_out (32 bits each)
   output logic [95:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   localparam int unsigned CSteps = (CORDIC_STEPS < TabLen) ? CORDIC_STEPS : TabLen;
   localparam int unsigned GShift = 32 - ANGLE_FRAC_BITS;
   localparam int unsigned ZShift = TabFrac - ANGLE_FRAC_BITS;

   // Sequencer states
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_MUL    = 4'd1;
   localparam logic [3:0] ST_CINIT  = 4'd2;
   localparam logic [3:0] ST_CITER  = 4'd3;
   localparam logic [3:0] ST_CDONE  = 4'd4;
   localparam logic [3:0] ST_BLEND  = 4'd5;
   localparam logic [3:0] ST_FINISH = 4'd6;
   localparam logic [3:0] ST_OUT    = 4'd7;

   logic [3:0]  state_ff, state_in;
   logic [2:0]  step_ff, step_in;        // multiply or blend step
   logic        axis_ff, axis_in;        // 0 pitch, 1 roll
   logic [4:0]  iter_ff, iter_in;

   logic [1:0]  mode_ff;
   logic [31:0] rate_gain_ff, yaw_gain_ff, roll_trim_ff;
   logic [16:0] gyro_wt_ff;
   logic [30:0] yaw_dband_ff;

   logic [31:0] pitch_ff, roll_ff, yaw_ff, held_ff;
   logic [31:0] pitch_in, roll_in, yaw_in, held_in;
   logic [95:0] sample_ff;
   logic [31:0] pg_ff, rg_ff, yg_ff, pa_ff, ra_ff;
   logic [31:0] pg_in, rg_in, yg_in, pa_in, ra_in;
   logic signed [40:0] cx_ff, cy_ff, cx_in, cy_in;
   logic signed [33:0] cz_ff, cz_in;
   logic signed [65:0] prod_ff;
   logic signed [65:0] acc_ff, acc_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [95:0] rsp_data_ff, rsp_data_in;

   // Shared multiplier operands
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod_in;

   logic signed [15:0] ax, ay, az, rx, ry, rz;
   assign ax = sample_ff[15:0];
   assign ay = sample_ff[31:16];
   assign az = sample_ff[47:32];
   assign rx = sample_ff[63:48];
   assign ry = sample_ff[79:64];
   assign rz = sample_ff[95:80];

   logic [16:0] wsat;
   assign wsat = (gyro_wt_ff > 17'd65536) ? 17'd65536 : gyro_wt_ff;

   // Select multiplier operands by step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_MUL) begin
         case (step_ff)
            3'd0: begin mul_a = 33'(ry); mul_b = {1'b0, rate_gain_ff}; end
            3'd1: begin mul_a = 33'(rx); mul_b = {1'b0, rate_gain_ff}; end
            default: begin
               mul_a = 33'(rz);
               mul_b = {1'b0, (mode_ff == MODE_FUSED) ? yaw_gain_ff : rate_gain_ff};
            end
         endcase
      end else begin
         case (step_ff)
            3'd0: begin mul_a = {16'd0, wsat}; mul_b = 33'(signed'(pg_ff)); end
            3'd1: begin mul_a = 33'(17'd65536 - wsat); mul_b = 33'(signed'(pa_ff)); end
            3'd2: begin mul_a = {16'd0, wsat}; mul_b = 33'(signed'(rg_ff)); end
            default: begin
               mul_a = 33'(17'd65536 - wsat); mul_b = 33'(signed'(ra_ff));
            end
         endcase
      end
      prod_in = mul_a * mul_b;
   end

   // Rounded shifts of the product, the blend sum and the CORDIC angle
   logic signed [65:0] gadd;
   logic [31:0] gdelta;
   assign gadd   = prod_ff + (66'sd1 <<< (GShift - 1));
   assign gdelta = 32'(gadd >>> GShift);

   logic signed [65:0] bsum;
   logic [31:0] bres;
   assign bsum = acc_ff + prod_ff + 66'sd32768;
   assign bres = 32'(bsum >>> 16);

   logic signed [33:0] zr;
   logic [31:0] zres;
   assign zr   = cz_ff + (34'sd1 <<< (ZShift - 1));
   assign zres = 32'(zr >>> ZShift);

   // CORDIC operands for the current axis
   logic signed [15:0] cy_src;
   assign cy_src = axis_ff ? ay : ax;

   // Yaw deadband
   logic [31:0] ydiff;
   logic [31:0] ymag;
   assign ydiff = yg_ff - held_ff;
   assign ymag  = ydiff[31] ? (32'd0 - ydiff) : ydiff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      axis_in      = axis_ff;
      iter_in      = iter_ff;
      pitch_in     = pitch_ff;
      roll_in      = roll_ff;
      yaw_in       = yaw_ff;
      held_in      = held_ff;
      pg_in        = pg_ff;
      rg_in        = rg_ff;
      yg_in        = yg_ff;
      pa_in        = pa_ff;
      ra_in        = ra_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               step_in = '0;
               axis_in = 1'b0;
               case (mode_ff)
                  MODE_GYRO, MODE_FUSED: state_in = ST_MUL;
                  MODE_ACCEL:            state_in = ST_CINIT;
                  default:               state_in = ST_OUT;
               endcase
            end
         end
         // Three gyro products, one a cycle, each registered and used in the following step
         ST_MUL: begin
            if (step_ff != 3'd0) begin
               case (step_ff)
                  3'd1: pg_in = pitch_ff - gdelta;
                  3'd2: rg_in = roll_ff + gdelta;
                  default: yg_in = yaw_ff + gdelta;
               endcase
            end
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd3) begin
               step_in = '0;
               if (mode_ff == MODE_GYRO) begin
                  pitch_in = pg_ff;
                  roll_in  = rg_ff;
                  yaw_in   = yaw_ff + gdelta;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_CINIT;
               end
            end
         end
         // Pre-rotate into the right half plane
         ST_CINIT: begin
            iter_in = '0;
            if (az < 0) begin
               cz_in = (cy_src >= 0) ? (34'sd180 <<< TabFrac) : -(34'sd180 <<< TabFrac);
               cx_in = 41'(-32'(az)) <<< 16;
               cy_in = 41'(-32'(cy_src)) <<< 16;
            end else begin
               cz_in = '0;
               cx_in = 41'(az) <<< 16;
               cy_in = 41'(cy_src) <<< 16;
            end
            state_in = ST_CITER;
            if (az == 0 && cy_src == 0) begin
               cz_in    = '0;
               state_in = ST_CDONE;
            end
         end
         // One vectoring rotation a cycle
         ST_CITER: begin
            if (cy_ff > 0) begin
               cx_in = cx_ff + (cy_ff >>> iter_ff);
               cy_in = cy_ff - (cx_ff >>> iter_ff);
               cz_in = cz_ff + 34'(atan_q24(iter_ff));
            end else if (cy_ff < 0) begin
               cx_in = cx_ff - (cy_ff >>> iter_ff);
               cy_in = cy_ff + (cx_ff >>> iter_ff);
               cz_in = cz_ff - 34'(atan_q24(iter_ff));
            end
            iter_in = iter_ff + 5'd1;
            if (cy_ff == 0 || iter_ff == 5'(CSteps - 1)) begin
               state_in = ST_CDONE;
            end
         end
         ST_CDONE: begin
            if (axis_ff == 1'b0) begin
               pa_in    = zres;
               axis_in  = 1'b1;
               state_in = ST_CINIT;
            end else begin
               ra_in = zres;
               step_in = '0;
               if (mode_ff == MODE_ACCEL) begin
                  pitch_in = pa_ff;
                  roll_in  = zres;
                  yaw_in   = '0;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_BLEND;
               end
            end
         end
         // Four weighted products, accumulated in pairs
         ST_BLEND: begin
            case (step_ff)
               3'd1: acc_in = prod_ff;
               3'd2: pitch_in = bres;
               3'd3: acc_in = prod_ff;
               default: ;
            endcase
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd4) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            roll_in  = bres - roll_trim_ff;
            yaw_in   = ({1'b0, ymag} > {2'b0, yaw_dband_ff}) ? yg_ff : held_ff;
            held_in  = yaw_in;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {yaw_ff, roll_ff, pitch_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         axis_ff      <= 1'b0;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         pitch_ff     <= '0;
         roll_ff      <= '0;
         yaw_ff       <= '0;
         held_ff      <= '0;
         mode_ff      <= MODE_FUSED;
         rate_gain_ff <= 32'd2618882;
         yaw_gain_ff  <= 32'd3767515;
         gyro_wt_ff   <= 17'd62415;
         yaw_dband_ff <= 31'd6554;
         roll_trim_ff <= 32'd655;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         axis_ff      <= axis_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
         pitch_ff     <= pitch_in;
         roll_ff      <= roll_in;
         yaw_ff       <= yaw_in;
         held_ff      <= held_in;
         if (csr_we) begin
            case (csr_index)
               CSR_MODE:      mode_ff      <= csr_wdata[1:0];
               CSR_RATE_GAIN: rate_gain_ff <= csr_wdata;
               CSR_YAW_GAIN:  yaw_gain_ff  <= csr_wdata;
               CSR_GYRO_WT:   gyro_wt_ff   <= csr_wdata[16:0];
               CSR_YAW_DBAND: yaw_dband_ff <= csr_wdata[30:0];
               CSR_ROLL_TRIM: roll_trim_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_tvalid) begin
         sample_ff <= req_tdata;
      end
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      pg_ff       <= pg_in;
      rg_ff       <= rg_in;
      yg_ff       <= yg_in;
      pa_ff       <= pa_in;
      ra_ff       <= ra_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cz_ff       <= cz_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
